[rtl/gapb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapb_pkg
// Shared types, codes and fixed-point helpers of the gated attention block.
// ----------------------------------------------------------------------------
package gapb_pkg;

    localparam int FEATURES_DEF   = 4;
    localparam int MAX_TOKENS_DEF = 16;
    localparam int VALUE_BITS_DEF = 16;

    localparam int FRAC   = 12;   // Q.12 fraction bits
    localparam int PORTS  = 4;    // feature and output ports
    localparam int WORD_W = 16;   // table word and port width
    localparam int RW     = 96;   // working width of the rounding helpers

    localparam logic signed [RW-1:0] RND_HALF = RW'(1) << (FRAC - 1);

    typedef enum logic [1:0] {
        FN_LOAD   = 2'd0,
        FN_TOKEN  = 2'd1,
        FN_NEWSEQ = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        SEL_VW   = 3'd0,
        SEL_GW   = 3'd1,
        SEL_OW   = 3'd2,
        SEL_OB   = 3'd3,
        SEL_PB   = 3'd4,
        SEL_RSV5 = 3'd5,
        SEL_RSV6 = 3'd6,
        SEL_RSV7 = 3'd7
    } t_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROJ,
        S_HWR,
        S_ACC,
        S_DIV0,
        S_DIV,
        S_GMUL,
        S_GFIN,
        S_OPROJ,
        S_FIN
    } t_state;

    typedef struct packed {
        logic proj_clr;
        logic proj_step;
        logic proj_fin;
        logic acc_clr;
        logic acc_step;
        logic div_start;
        logic div_step;
        logic gate_mul;
        logic gate_fin;
    } t_lane_ctl;

    typedef struct packed {
        logic clr;
        logic step;
    } t_merge_ctl;

    // divide by 2^FRAC, round half away from zero
    function automatic logic signed [RW-1:0] rnd_q12(input logic signed [RW-1:0] a);
        logic signed [RW-1:0] m;
        m = -a;
        if (a >= 0) begin
            return (a + RND_HALF) >>> FRAC;
        end
        return -((m + RND_HALF) >>> FRAC);
    endfunction

    function automatic logic signed [RW-1:0] sat_bits(input logic signed [RW-1:0] a,
                                                      input int unsigned bits);
        logic signed [RW-1:0] hi;
        logic signed [RW-1:0] lo;
        hi = (RW'(1) << (bits - 1)) - RW'(1);
        lo = ~hi;
        if (a > hi) begin
            return hi;
        end
        if (a < lo) begin
            return lo;
        end
        return a;
    endfunction

endpackage

[rtl/gated_attention_position_bias.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_attention_position_bias
// Single-head gated attention with a learned token-by-token position bias.
// ----------------------------------------------------------------------------
// One request at a time. A load request (func 0) writes one table word and a
// new-sequence request (func 2) clears the token count; neither gives a
// result. A token request (func 1) runs, once taken, through value/gate
// projection over the features, a store of the value row, a walk of the
// position-bias row and the value history (one read port on each memory),
// the one-bit-per-cycle restoring divide, the gate multiply, the output
// projection and the posting of the result; the next request is taken in
// the cycle after. Posting waits while an earlier result is still held at
// the output. Each feature has a lane of its own; the lanes run side by
// side and the merge stage projects their gated results. A token that
// arrives with the sequence full skips to the final step and posts a result
// with too_long set and zero outputs. The result sits in an output
// register, so a new request is taken while it waits. Tables and history
// hold no reset value: reading a word that was never loaded gives an
// unspecified result.
// ----------------------------------------------------------------------------
module gated_attention_position_bias #(
    parameter int FEATURES   = gapb_pkg::FEATURES_DEF,
    parameter int MAX_TOKENS = gapb_pkg::MAX_TOKENS_DEF,
    parameter int VALUE_BITS = gapb_pkg::VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_func,
    input  logic [2:0]         i_table_sel,
    input  logic [3:0]         i_row_index,
    input  logic [3:0]         i_col_index,
    input  logic signed [15:0] i_weight_value,
    input  logic signed [15:0] i_feature_0,
    input  logic signed [15:0] i_feature_1,
    input  logic signed [15:0] i_feature_2,
    input  logic signed [15:0] i_feature_3,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_out_0,
    output logic signed [15:0] o_out_1,
    output logic signed [15:0] o_out_2,
    output logic signed [15:0] o_out_3,
    output logic [3:0]         o_token_position,
    output logic               o_too_long,
    output logic               o_zero_denominator
);
    import gapb_pkg::*;

    localparam int FW   = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int PW   = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int CW   = $clog2(MAX_TOKENS + 1);
    localparam int BW   = 16 + PW + 1;
    localparam int NPB  = MAX_TOKENS * MAX_TOKENS;
    localparam int ADW  = (NPB > 1) ? $clog2(NPB) : 1;
    localparam int DCW  = $clog2(VALUE_BITS + 1);
    localparam int NOUT = (FEATURES < PORTS) ? FEATURES : PORTS;
    localparam int RB   = (NOUT > 1) ? $clog2(NOUT) : 1;

    // control
    t_state               r_state, n_state;
    logic [FW-1:0]        r_k;
    logic [PW:0]          r_s;
    logic [DCW-1:0]       r_dc;
    logic [CW-1:0]        r_cnt;
    logic [PW-1:0]        r_p;
    logic                 r_too_long;
    logic                 r_out_valid;

    // payload
    logic signed [15:0]   r_x [PORTS];
    logic signed [BW-1:0] r_bsum;
    logic signed [15:0]   r_bias_q;
    logic signed [15:0]   r_pb [NPB];
    logic signed [15:0]   r_out_y [PORTS];
    logic [3:0]           r_out_pos;
    logic                 r_out_tl;
    logic                 r_out_zd;

    t_lane_ctl                   lane_ctl;
    t_merge_ctl                  merge_ctl;
    logic                        in_acc, ld, tok, full, out_free;
    logic signed [15:0]          x_k;
    logic signed [VALUE_BITS-1:0] lane_o [FEATURES];
    logic signed [15:0]          m_y [PORTS];
    logic [ADW-1:0]              pb_waddr, pb_raddr;
    logic                        pb_we, col_ok_f;
    logic [FW-1:0]               k_last;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign ld         = in_acc && (i_func == FN_LOAD);
    assign tok        = in_acc && (i_func == FN_TOKEN);
    assign full       = (r_cnt >= CW'(MAX_TOKENS));
    assign out_free   = !r_out_valid || i_out_ready;
    assign k_last     = FW'(FEATURES - 1);
    assign col_ok_f   = (int'(i_col_index) < FEATURES);

    // features beyond PORTS read as zero
    assign x_k = (int'(r_k) < PORTS) ? r_x[2'(r_k)] : 16'sd0;

    // position-bias table: row = current token, column = earlier or current token
    assign pb_we    = ld && (i_table_sel == SEL_PB) && (int'(i_row_index) < MAX_TOKENS)
                      && (int'(i_col_index) < MAX_TOKENS);
    assign pb_waddr = ADW'(i_row_index) * ADW'(MAX_TOKENS) + ADW'(i_col_index);
    assign pb_raddr = ADW'(r_p) * ADW'(MAX_TOKENS) + ADW'(r_s[PW-1:0]);

    always_ff @(posedge i_clk) begin
        if (pb_we) begin
            r_pb[pb_waddr] <= i_weight_value;
        end
        r_bias_q <= r_pb[pb_raddr];
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state   = r_state;
        lane_ctl  = '0;
        merge_ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                if (tok) begin
                    if (full) begin
                        n_state = S_FIN;
                    end else begin
                        lane_ctl.proj_clr = 1'b1;
                        n_state = S_PROJ;
                    end
                end
            end
            S_PROJ: begin
                lane_ctl.proj_step = 1'b1;
                if (r_k == k_last) begin
                    n_state = S_HWR;
                end
            end
            S_HWR: begin
                lane_ctl.proj_fin = 1'b1;
                lane_ctl.acc_clr  = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                // read issued at r_s, data summed in the cycle after
                lane_ctl.acc_step = (r_s != '0);
                if (r_s == ({1'b0, r_p} + (PW + 1)'(1))) begin
                    n_state = S_DIV0;
                end
            end
            S_DIV0: begin
                lane_ctl.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                lane_ctl.div_step = 1'b1;
                if (r_dc == DCW'(VALUE_BITS)) begin
                    n_state = S_GMUL;
                end
            end
            S_GMUL: begin
                lane_ctl.gate_mul = 1'b1;
                n_state = S_GFIN;
            end
            S_GFIN: begin
                lane_ctl.gate_fin = 1'b1;
                merge_ctl.clr     = 1'b1;
                n_state = S_OPROJ;
            end
            S_OPROJ: begin
                merge_ctl.step = 1'b1;
                if (r_k == k_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_s         <= '0;
            r_dc        <= '0;
            r_cnt       <= '0;
            r_too_long  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PROJ || r_state == S_OPROJ) begin
                r_k <= (r_k == k_last) ? '0 : r_k + FW'(1);
            end
            if (r_state == S_HWR) begin
                r_s <= '0;
            end else if (r_state == S_ACC) begin
                r_s <= r_s + (PW + 1)'(1);
            end
            if (r_state == S_DIV0) begin
                r_dc <= '0;
            end else if (r_state == S_DIV) begin
                r_dc <= r_dc + DCW'(1);
            end
            if (in_acc && i_func == FN_NEWSEQ) begin
                r_cnt <= '0;
            end else if (r_state == S_HWR) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (tok) begin
                r_too_long <= full;
            end
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // token payload and result registers
    always_ff @(posedge i_clk) begin
        if (tok) begin
            r_x[0] <= i_feature_0;
            r_x[1] <= i_feature_1;
            r_x[2] <= i_feature_2;
            r_x[3] <= i_feature_3;
            r_p    <= r_cnt[PW-1:0];
        end
        if (r_state == S_HWR) begin
            r_bsum <= '0;
        end else if (r_state == S_ACC && r_s != '0) begin
            r_bsum <= r_bsum + BW'(r_bias_q);
        end
        if (r_state == S_FIN && out_free) begin
            for (int j = 0; j < PORTS; j++) begin
                r_out_y[j] <= r_too_long ? 16'sd0 : m_y[j];
            end
            r_out_pos <= r_too_long ? 4'd0 : 4'(r_p);
            r_out_tl  <= r_too_long;
            r_out_zd  <= !r_too_long && (r_bsum == '0);
        end
    end

    // ---------------- lanes ----------------
    for (genvar d = 0; d < FEATURES; d++) begin : g_lane
        logic wr_v, wr_g;
        assign wr_v = ld && (i_table_sel == SEL_VW) && (i_row_index == 4'(d)) && col_ok_f;
        assign wr_g = ld && (i_table_sel == SEL_GW) && (i_row_index == 4'(d)) && col_ok_f;

        gapb_lane #(
            .FEATURES   (FEATURES),
            .MAX_TOKENS (MAX_TOKENS),
            .VALUE_BITS (VALUE_BITS)
        ) u_lane (
            .i_clk        (i_clk),
            .i_ctl        (lane_ctl),
            .i_wr_v       (wr_v),
            .i_wr_g       (wr_g),
            .i_wr_col     (i_col_index[FW-1:0]),
            .i_wr_data    (i_weight_value),
            .i_k          (r_k),
            .i_x          (x_k),
            .i_hist_waddr (r_p),
            .i_hist_raddr (r_s[PW-1:0]),
            .i_bias       (r_bias_q),
            .i_bsum       (r_bsum),
            .o_o          (lane_o[d])
        );
    end

    // ---------------- merge ----------------
    logic m_wr_w, m_wr_b;
    assign m_wr_w = ld && (i_table_sel == SEL_OW) && (int'(i_row_index) < NOUT) && col_ok_f;
    assign m_wr_b = ld && (i_table_sel == SEL_OB) && (int'(i_col_index) < NOUT);

    gapb_merge #(
        .FEATURES   (FEATURES),
        .VALUE_BITS (VALUE_BITS)
    ) u_merge (
        .i_clk     (i_clk),
        .i_ctl     (merge_ctl),
        .i_wr_w    (m_wr_w),
        .i_wr_b    (m_wr_b),
        .i_wr_row  (i_row_index[RB-1:0]),
        .i_wr_col  (i_col_index[FW-1:0]),
        .i_wr_data (i_weight_value),
        .i_i       (r_k),
        .i_o       (lane_o[r_k]),
        .o_y       (m_y)
    );

    assign o_out_valid        = r_out_valid;
    assign o_out_0            = r_out_y[0];
    assign o_out_1            = r_out_y[1];
    assign o_out_2            = r_out_y[2];
    assign o_out_3            = r_out_y[3];
    assign o_token_position   = r_out_pos;
    assign o_too_long         = r_out_tl;
    assign o_zero_denominator = r_out_zd;

    // ---------------- checks ----------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_TOKENS))
        else $error("token count beyond capacity");

    a_post_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_FIN)
        else $error("result posted outside the final step");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_tl) |-> (r_out_y[0] == 16'sd0 && r_out_y[1] == 16'sd0
            && r_out_y[2] == 16'sd0 && r_out_y[3] == 16'sd0 && !r_out_zd))
        else $error("full-sequence result carries data");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_s <= ({1'b0, r_p} + (PW + 1)'(1))))
        else $error("bias row walk past the current token");

endmodule

[rtl/gapb_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapb_lane
// One feature lane: value/gate projection, history column, weighted sum,
// restoring divide by the bias sum and gate multiply.
// ----------------------------------------------------------------------------
module gapb_lane #(
    parameter int FEATURES   = gapb_pkg::FEATURES_DEF,
    parameter int MAX_TOKENS = gapb_pkg::MAX_TOKENS_DEF,
    parameter int VALUE_BITS = gapb_pkg::VALUE_BITS_DEF,
    localparam int FW  = (FEATURES > 1) ? $clog2(FEATURES) : 1,
    localparam int PW  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1,
    localparam int BW  = 16 + PW + 1,
    localparam int AW  = 16 + VALUE_BITS + PW + 1,
    localparam int XW  = AW + VALUE_BITS + 3,
    localparam int PAW = 32 + FW + 1
) (
    input  logic                         i_clk,
    input  gapb_pkg::t_lane_ctl          i_ctl,
    input  logic                         i_wr_v,
    input  logic                         i_wr_g,
    input  logic [FW-1:0]                i_wr_col,
    input  logic signed [15:0]           i_wr_data,
    input  logic [FW-1:0]                i_k,
    input  logic signed [15:0]           i_x,
    input  logic [PW-1:0]                i_hist_waddr,
    input  logic [PW-1:0]                i_hist_raddr,
    input  logic signed [15:0]           i_bias,
    input  logic signed [BW-1:0]         i_bsum,
    output logic signed [VALUE_BITS-1:0] o_o
);
    import gapb_pkg::*;

    localparam int VB = VALUE_BITS;
    localparam logic [VB:0] QLIM = (VB + 1)'(1) << (VB - 1);

    logic signed [15:0]     r_wv [FEATURES];
    logic signed [15:0]     r_wg [FEATURES];
    logic signed [VB-1:0]   r_hist [MAX_TOKENS];
    logic signed [VB-1:0]   r_hist_q;
    logic signed [PAW-1:0]  r_acc_v, r_acc_u;
    logic signed [VB-1:0]   r_u;
    logic signed [AW-1:0]   r_acc_a;
    logic [XW-1:0]          r_num, r_dsh;
    logic [VB:0]            r_q;
    logic                   r_ovf, r_neg, r_zd, r_apos, r_aneg;
    logic signed [2*VB-1:0] r_gp;
    logic signed [VB-1:0]   r_o;

    logic signed [31:0]      pv, pu;
    logic signed [VB-1:0]    v_new, u_new;
    logic signed [16+VB-1:0] pa;
    logic signed [XW-1:0]    a_ext, b_ext;
    logic [XW-1:0]           mag_a, mag_b, num0;
    logic                    qbit;
    logic [VB:0]             qc;
    logic signed [RW-1:0]    qs;
    logic signed [VB-1:0]    val;
    logic signed [2*VB-1:0]  gp;

    assign pv = r_wv[i_k] * i_x;
    assign pu = r_wg[i_k] * i_x;
    assign v_new = VB'(sat_bits(rnd_q12(RW'(r_acc_v)), VB));
    assign u_new = VB'(sat_bits(rnd_q12(RW'(r_acc_u)), VB));
    assign pa    = i_bias * r_hist_q;
    assign a_ext = XW'(r_acc_a);
    assign b_ext = XW'(i_bsum);
    assign mag_a = (r_acc_a < 0) ? XW'(-a_ext) : XW'(a_ext);
    assign mag_b = (i_bsum < 0) ? XW'(-b_ext) : XW'(b_ext);
    assign num0  = mag_a + (mag_b >> 1);
    assign qbit  = (r_num >= r_dsh);
    assign gp    = r_u * val;

    always_comb begin
        qc = (r_ovf || (r_q > QLIM)) ? QLIM : r_q;
        qs = RW'(qc);
        if (r_neg) begin
            qs = -qs;
        end
        if (r_zd) begin
            // zero bias sum: saturate toward the sign of the weighted sum
            qs = r_apos ? (RW'(1) <<< VB) : (r_aneg ? -(RW'(1) <<< VB) : RW'(0));
        end
        val = VB'(sat_bits(qs, VB));
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_v) begin
            r_wv[i_wr_col] <= i_wr_data;
        end
        if (i_wr_g) begin
            r_wg[i_wr_col] <= i_wr_data;
        end
        if (i_ctl.proj_fin) begin
            r_hist[i_hist_waddr] <= v_new;
        end
        r_hist_q <= r_hist[i_hist_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.proj_clr) begin
            r_acc_v <= '0;
            r_acc_u <= '0;
        end else if (i_ctl.proj_step) begin
            r_acc_v <= r_acc_v + PAW'(pv);
            r_acc_u <= r_acc_u + PAW'(pu);
        end
        if (i_ctl.proj_fin) begin
            r_u <= u_new;
        end
        if (i_ctl.acc_clr) begin
            r_acc_a <= '0;
        end else if (i_ctl.acc_step) begin
            r_acc_a <= r_acc_a + AW'(pa);
        end
        if (i_ctl.div_start) begin
            r_num  <= num0;
            r_dsh  <= mag_b << VB;
            r_ovf  <= (num0 >= (mag_b << (VB + 1)));
            r_neg  <= (r_acc_a < 0) != (i_bsum < 0);
            r_zd   <= (i_bsum == 0);
            r_apos <= (r_acc_a > 0);
            r_aneg <= (r_acc_a < 0);
            r_q    <= '0;
        end else if (i_ctl.div_step) begin
            if (qbit) begin
                r_num <= r_num - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[VB-1:0], qbit};
        end
        if (i_ctl.gate_mul) begin
            r_gp <= gp;
        end
        if (i_ctl.gate_fin) begin
            r_o <= VB'(sat_bits(rnd_q12(RW'(r_gp)), VB));
        end
    end

    assign o_o = r_o;

endmodule

[rtl/gapb_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapb_merge
// Output projection: combines the lane results through Wo and adds bo.
// ----------------------------------------------------------------------------
module gapb_merge #(
    parameter int FEATURES   = gapb_pkg::FEATURES_DEF,
    parameter int VALUE_BITS = gapb_pkg::VALUE_BITS_DEF,
    localparam int FW   = (FEATURES > 1) ? $clog2(FEATURES) : 1,
    localparam int NOUT = (FEATURES < gapb_pkg::PORTS) ? FEATURES : gapb_pkg::PORTS,
    localparam int RB   = (NOUT > 1) ? $clog2(NOUT) : 1
) (
    input  logic                         i_clk,
    input  gapb_pkg::t_merge_ctl         i_ctl,
    input  logic                         i_wr_w,
    input  logic                         i_wr_b,
    input  logic [RB-1:0]                i_wr_row,
    input  logic [FW-1:0]                i_wr_col,
    input  logic signed [15:0]           i_wr_data,
    input  logic [FW-1:0]                i_i,
    input  logic signed [VALUE_BITS-1:0] i_o,
    output logic signed [15:0]           o_y [gapb_pkg::PORTS]
);
    import gapb_pkg::*;

    localparam int MW = 16 + VALUE_BITS + FW + FRAC + 2;

    logic signed [15:0]   r_wo [NOUT][FEATURES];
    logic signed [15:0]   r_bo [NOUT];
    logic signed [MW-1:0] r_acc [NOUT];

    always_ff @(posedge i_clk) begin
        if (i_wr_w) begin
            r_wo[i_wr_row][i_wr_col] <= i_wr_data;
        end
        if (i_wr_b) begin
            r_bo[i_wr_col[RB-1:0]] <= i_wr_data;
        end
    end

    for (genvar j = 0; j < PORTS; j++) begin : g_out
        if (j < NOUT) begin : g_used
            logic signed [16+VALUE_BITS-1:0] pm;
            assign pm = r_wo[j][i_i] * i_o;
            always_ff @(posedge i_clk) begin
                if (i_ctl.clr) begin
                    r_acc[j] <= MW'(r_bo[j]) <<< FRAC;
                end else if (i_ctl.step) begin
                    r_acc[j] <= r_acc[j] + MW'(pm);
                end
            end
            assign o_y[j] = 16'(sat_bits(rnd_q12(RW'(r_acc[j])), WORD_W));
        end else begin : g_zero
            assign o_y[j] = '0;
        end
    end

endmodule
